// ===== hw/rtl/gehc_pkg.sv =====
// ----------------------------------------------------------------------------
// gehc_pkg: shared types and constants
// Operation codes plus the command and status words passed between the
// controller and the datapath of the Euler and Hamilton cycle checker.
// ----------------------------------------------------------------------------
package gehc_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int unsigned VcountW = 5;
  localparam logic [VcountW-1:0] VcountReset = 5'd16;

  typedef struct packed {
    logic add_edge;
    logic clear;
    logic act_start;
    logic act_step;
    logic seed;
    logic walk_step;
    logic ham_init;
    logic ham_step;
    logic ham_load;
  } gehc_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic walk_changed;
    logic ham_found;
    logic ham_pop;
    logic ham_fail;
  } gehc_sts_t;

endpackage

// ===== hw/rtl/gehc_datapath.sv =====
// ----------------------------------------------------------------------------
// gehc_datapath: graph store and search datapath
// Holds the adjacency rows, parity bits, reachability masks and the
// backtracking stack, and carries out one controller command per cycle.
// ----------------------------------------------------------------------------
module gehc_datapath #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gehc_pkg::gehc_cmd_t cmd_i,
  output gehc_pkg::gehc_sts_t sts_o,
  input  logic [3:0]         vertex_a_i,
  input  logic [3:0]         vertex_b_i,
  input  logic               vertex_count_we_i,
  input  logic [4:0]         vertex_count_i,
  output logic               euler_cycle_o,
  output logic               hamilton_cycle_o,
  output logic               edges_connected_o
);
  import gehc_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1) > 0 ? $clog2(MAX_VERTICES + 1) : 1;
  localparam int unsigned EW = CW + VW;

  logic [VcountW-1:0]      vcount_q;
  logic [MAX_VERTICES-1:0] rows_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] parity_q, active_q, visited_q, in_path_q;
  logic [MAX_VERTICES-1:0] visited_d, mask, a_dec, b_dec, row_m, ge, cands;
  logic [VW-1:0]           v_q, prev_q, rd_idx, c_idx;
  logic [CW-1:0]           n, cand_q, d_q, dm1;
  logic                    changed_q, conn_q, ham_q, a_ok, b_ok, hit, at_n;
  logic [EW-1:0]           mem [MAX_VERTICES];
  logic [EW-1:0]           rd_q;

  always_comb begin
    if (vcount_q == '0) begin
      n = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vcount_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i]  = i < 32'(n);
      a_dec[i] = 32'(vertex_a_i) == i;
      b_dec[i] = 32'(vertex_b_i) == i;
      ge[i]    = i >= 32'(cand_q);
    end
  end

  assign a_ok   = 32'(vertex_a_i) < 32'(n);
  assign b_ok   = 32'(vertex_b_i) < 32'(n);
  assign rd_idx = cmd_i.ham_step ? prev_q : v_q;
  assign row_m  = rows_q[rd_idx] & mask;
  assign cands  = row_m & ~in_path_q & ge;
  assign at_n   = d_q == n;
  assign dm1    = d_q - CW'(1);

  always_comb begin
    hit   = 1'b0;
    c_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cands[i]) begin
        hit   = 1'b1;
        c_idx = VW'(i);
      end
    end
  end

  always_comb begin
    visited_d = visited_q;
    if (visited_q[v_q]) begin
      visited_d = visited_q | row_m;
    end
  end

  always_comb begin
    sts_o.sweep_last   = CW'(v_q) == n - CW'(1);
    sts_o.walk_changed = changed_q | (visited_d != visited_q);
    sts_o.ham_found    = cmd_i.ham_step & at_n & row_m[0];
    sts_o.ham_pop      = cmd_i.ham_step & ~(at_n & row_m[0]) & (at_n | ~hit);
    sts_o.ham_fail     = sts_o.ham_pop & (d_q == CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
    end else if (vertex_count_we_i) begin
      vcount_q <= vertex_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_q[i] <= '0;
      end
      parity_q <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_q[i] <= '0;
      end
      parity_q <= '0;
    end else if (cmd_i.add_edge && a_ok && b_ok) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (a_dec[i]) begin
          rows_q[i] <= rows_q[i] | b_dec | (b_dec[i] ? a_dec : '0);
        end else if (b_dec[i]) begin
          rows_q[i] <= rows_q[i] | a_dec;
        end
      end
      if (vertex_a_i != vertex_b_i) begin
        parity_q <= parity_q ^ a_dec ^ b_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      active_q  <= '0;
      visited_q <= '0;
      changed_q <= 1'b0;
      in_path_q <= '0;
      d_q       <= '0;
      prev_q    <= '0;
      cand_q    <= '0;
      conn_q    <= 1'b0;
      ham_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        visited_q <= '0;
        in_path_q <= '0;
        d_q       <= '0;
      end
      if (cmd_i.act_start) begin
        v_q      <= '0;
        active_q <= '0;
      end
      if (cmd_i.act_step) begin
        active_q[v_q] <= |row_m;
        v_q           <= v_q + VW'(1);
      end
      if (cmd_i.seed) begin
        visited_q <= active_q & (~active_q + MAX_VERTICES'(1));
        v_q       <= '0;
        changed_q <= 1'b0;
      end
      if (cmd_i.walk_step) begin
        visited_q <= visited_d;
        if (sts_o.sweep_last) begin
          v_q       <= '0;
          changed_q <= 1'b0;
        end else begin
          v_q       <= v_q + VW'(1);
          changed_q <= sts_o.walk_changed;
        end
      end
      if (cmd_i.ham_init) begin
        conn_q    <= (active_q & ~visited_q) == '0;
        ham_q     <= 1'b0;
        prev_q    <= '0;
        d_q       <= CW'(1);
        cand_q    <= CW'(1);
        in_path_q <= MAX_VERTICES'(1);
      end
      if (cmd_i.ham_step) begin
        if (sts_o.ham_found) begin
          ham_q <= 1'b1;
        end else if (sts_o.ham_pop) begin
          in_path_q[prev_q] <= 1'b0;
          d_q               <= dm1;
        end else begin
          in_path_q[c_idx] <= 1'b1;
          prev_q           <= c_idx;
          d_q              <= d_q + CW'(1);
          cand_q           <= CW'(1);
        end
      end
      if (cmd_i.ham_load) begin
        cand_q <= rd_q[EW-1:VW];
        prev_q <= rd_q[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ham_step && !at_n && hit) begin
      mem[d_q[VW-1:0]] <= {CW'(c_idx) + CW'(1), prev_q};
    end
    rd_q <= mem[dm1[VW-1:0]];
  end

  assign edges_connected_o = conn_q;
  assign hamilton_cycle_o  = ham_q;
  assign euler_cycle_o     = conn_q & ((parity_q & mask) == '0);

endmodule

// ===== hw/rtl/gehc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gehc_ctrl: sequencing controller
// Decodes accepted words and steps the datapath through the activity
// sweep, the reachability walk and the backtracking search.
// ----------------------------------------------------------------------------
module gehc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          operation_i,
  output logic                busy_o,
  output logic                done_o,
  output gehc_pkg::gehc_cmd_t cmd_o,
  input  gehc_pkg::gehc_sts_t sts_i
);
  import gehc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACT   = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_HINIT = 3'd4;
  localparam logic [2:0] S_HSTEP = 3'd5;
  localparam logic [2:0] S_HLOAD = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       go;

  assign go     = start_i & (state_q == S_IDLE);
  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          case (operation_i)
            OP_ADD:   cmd_o.add_edge = 1'b1;
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_EVAL: begin
              cmd_o.act_start = 1'b1;
              state_d         = S_ACT;
            end
            default: ;
          endcase
        end
      end
      S_ACT: begin
        cmd_o.act_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_SEED;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.sweep_last && !sts_i.walk_changed) state_d = S_HINIT;
      end
      S_HINIT: begin
        cmd_o.ham_init = 1'b1;
        state_d        = S_HSTEP;
      end
      S_HSTEP: begin
        cmd_o.ham_step = 1'b1;
        if (sts_i.ham_found || sts_i.ham_fail) begin
          state_d = S_DONE;
        end else if (sts_i.ham_pop) begin
          state_d = S_HLOAD;
        end
      end
      S_HLOAD: begin
        cmd_o.ham_load = 1'b1;
        state_d        = S_HSTEP;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("controller not idle after result");
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && operation_i == OP_EVAL) |=> busy_o) else $error("evaluate not started");
  a_edge_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && operation_i != OP_EVAL) |=> !busy_o) else $error("edge word stalled");

endmodule

// ===== hw/rtl/graph_euler_hamilton_cycle_check.sv =====
// ----------------------------------------------------------------------------
// graph_euler_hamilton_cycle_check: Euler and Hamilton cycle checker
// Loads undirected edges into an adjacency bit matrix and, on request,
// reports connectivity, the Euler property and a Hamilton cycle.
//
// Channel  | Handshake               | Words
// command  | start_i, busy_o         | operation_i, vertex_a_i, vertex_b_i
// config   | vertex_count_we_i       | vertex_count_i
// result   | done_o (one cycle)      | euler_cycle_o, hamilton_cycle_o,
//          |                         | edges_connected_o
//
// Add-edge, clear and unused words are carried out in the idle state; busy stays low.
// An evaluate word runs the activity sweep, a seed step, the walk passes
// (at most n passes), a search init step, the search steps with a reload
// after each backtrack that does not end the search, and a done state;
// the backtracking search sets the worst case.
// Reset empties the graph and sets the vertex count to 16.
// The receiver cannot stall; done_o is high for exactly one cycle.
// ----------------------------------------------------------------------------
module graph_euler_hamilton_cycle_check #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] vertex_a_i,
  input  logic [3:0] vertex_b_i,
  input  logic       vertex_count_we_i,
  input  logic [4:0] vertex_count_i,
  output logic       done_o,
  output logic       euler_cycle_o,
  output logic       hamilton_cycle_o,
  output logic       edges_connected_o
);
  import gehc_pkg::*;

  gehc_cmd_t cmd;
  gehc_sts_t sts;

  gehc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gehc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .vertex_count_we_i (vertex_count_we_i),
    .vertex_count_i    (vertex_count_i),
    .euler_cycle_o     (euler_cycle_o),
    .hamilton_cycle_o  (hamilton_cycle_o),
    .edges_connected_o (edges_connected_o)
  );

endmodule
